// File: design/sbbl_pkg.sv
// Shared types and constants of the spectral band beat level unit.
`timescale 1ns / 1ps
package sbbl_pkg;

	typedef struct packed {
		logic [8:0] bass_upper;
		logic [8:0] mid_upper;
		logic [9:0] treble_upper;
	} band_limits_t;

	localparam logic [1:0] CFG_BASS_UPPER   = 2'd0;
	localparam logic [1:0] CFG_MID_UPPER    = 2'd1;
	localparam logic [1:0] CFG_TREBLE_UPPER = 2'd2;

	localparam logic [8:0] BASS_UPPER_RST   = 9'd3;
	localparam logic [8:0] MID_UPPER_RST    = 9'd23;
	localparam logic [9:0] TREBLE_UPPER_RST = 10'd255;

	localparam int NUM_BANDS = 4;

	// 100.0 in Q7.8
	localparam logic [14:0] LEVEL_MAX = 15'd25600;
	// raw values at or above this always saturate the attack
	localparam logic [16:0] RAW_CLAMP = 17'd64000;
	// ceil(2^18 / 5); exact floor(x / 5) for x below 2^18
	localparam logic [15:0] RECIP5    = 16'd52429;

endpackage

// File: design/spectral_band_beat_levels_unit.sv
// Top level of the spectral band beat level unit.
// channel  signals                                       direction
// in       in_valid/in_ready, left/right_magnitude,      request in
//          frame_end
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data      request in
// out      out_valid/out_ready, *_level, *_attack        request out
// One bin a cycle while the frame queue has room; the last bin of a frame queues it.
// The back end works through the four bands in turn (read, total, divide, attack), DW = MAGNITUDE_BITS
// + 17 + clog2(AVERAGE_DEPTH+1) dividend bits through the one-bit-a-cycle divider.
// The front stalls only when two frames wait; a stalled result holds back the next.
// Reset clears control state, totals and attack state at once; history reads zero until filled.
`timescale 1ns / 1ps
module spectral_band_beat_levels_unit #(
	parameter int FFT_LENGTH     = 512,
	parameter int AVERAGE_DEPTH  = 16,
	parameter int MAGNITUDE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [MAGNITUDE_BITS-1:0] left_magnitude,
	input  logic [MAGNITUDE_BITS-1:0] right_magnitude,
	input  logic                      frame_end,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [9:0]                cfg_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [14:0]               bass_level,
	output logic [14:0]               mid_level,
	output logic [14:0]               treble_level,
	output logic [14:0]               volume_level,
	output logic [14:0]               bass_attack,
	output logic [14:0]               mid_attack,
	output logic [14:0]               treble_attack,
	output logic [14:0]               volume_attack
);

	localparam int AW = MAGNITUDE_BITS + 9;

	sbbl_pkg::band_limits_t    limits_q;
	logic                      push, q_not_full, q_not_empty, pop;
	logic [3:0][AW-1:0]        push_data, q_head;
	logic [3:0][14:0]          levels, attacks;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.bass_upper   <= sbbl_pkg::BASS_UPPER_RST;
			limits_q.mid_upper    <= sbbl_pkg::MID_UPPER_RST;
			limits_q.treble_upper <= sbbl_pkg::TREBLE_UPPER_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sbbl_pkg::CFG_BASS_UPPER:   limits_q.bass_upper   <= cfg_data[8:0];
				sbbl_pkg::CFG_MID_UPPER:    limits_q.mid_upper    <= cfg_data[8:0];
				sbbl_pkg::CFG_TREBLE_UPPER: limits_q.treble_upper <= cfg_data;
				default: ;
			endcase
		end
	end

	sbbl_front #(
		.FFT_LENGTH     (FFT_LENGTH),
		.MAGNITUDE_BITS (MAGNITUDE_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.limits          (limits_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.left_magnitude  (left_magnitude),
		.right_magnitude (right_magnitude),
		.frame_end       (frame_end),
		.push            (push),
		.push_data       (push_data),
		.q_ready         (q_not_full)
	);

	sbbl_queue #(
		.WIDTH (4 * AW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.not_full  (q_not_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	sbbl_back #(
		.AVERAGE_DEPTH  (AVERAGE_DEPTH),
		.MAGNITUDE_BITS (MAGNITUDE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.levels    (levels),
		.attacks   (attacks)
	);

	assign bass_level    = levels[0];
	assign mid_level     = levels[1];
	assign treble_level  = levels[2];
	assign volume_level  = levels[3];
	assign bass_attack   = attacks[0];
	assign mid_attack    = attacks[1];
	assign treble_attack = attacks[2];
	assign volume_attack = attacks[3];

endmodule

// File: design/sbbl_front.sv
// Front end: bin counting and band accumulation, pushes frame intensities.
`timescale 1ns / 1ps
module sbbl_front #(
	parameter int FFT_LENGTH     = 512,
	parameter int MAGNITUDE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sbbl_pkg::band_limits_t        limits,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [MAGNITUDE_BITS-1:0]     left_magnitude,
	input  logic [MAGNITUDE_BITS-1:0]     right_magnitude,
	input  logic                          frame_end,
	output logic                          push,
	output logic [3:0][MAGNITUDE_BITS+8:0] push_data,
	input  logic                          q_ready
);

	localparam int AW = MAGNITUDE_BITS + 9;
	localparam int IW = $clog2(FFT_LENGTH);
	localparam int CW = (IW > 10) ? IW : 10;

	logic [IW-1:0]    idx_q;
	logic [2:0][AW-1:0] acc_q;
	logic [2:0][AW-1:0] acc_nx;
	logic [MAGNITUDE_BITS:0] sum;
	logic [CW-1:0]    idx_c;
	logic [AW-1:0]    v01, vol;
	logic             accept;

	function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[AW] ? {AW{1'b1}} : s[AW-1:0];
	endfunction

	assign in_ready = q_ready;
	assign accept   = in_valid & in_ready;
	assign sum      = {1'b0, left_magnitude} + {1'b0, right_magnitude};
	assign idx_c    = CW'(idx_q);

	always_comb begin
		acc_nx = acc_q;
		if (idx_c < CW'(limits.bass_upper))
			acc_nx[0] = sat_add(acc_q[0], AW'(sum));
		else if (idx_c < CW'(limits.mid_upper))
			acc_nx[1] = sat_add(acc_q[1], AW'(sum));
		else if (idx_c < CW'(limits.treble_upper))
			acc_nx[2] = sat_add(acc_q[2], AW'(sum));
	end

	assign v01 = sat_add(acc_nx[0], acc_nx[1]);
	assign vol = sat_add(v01, acc_nx[2]);

	assign push      = accept & frame_end;
	assign push_data = {vol, acc_nx[2], acc_nx[1], acc_nx[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			acc_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				idx_q <= '0;
				acc_q <= '0;
			end else begin
				acc_q <= acc_nx;
				idx_q <= (idx_q == IW'(FFT_LENGTH - 1)) ? '0 : idx_q + 1'b1;
			end
		end
	end

endmodule

// File: design/sbbl_queue.sv
// Two-entry queue of frame intensities between front and back.
`timescale 1ns / 1ps
module sbbl_queue #(
	parameter int WIDTH = 100
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             not_full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;

	assign not_full  = (cnt_q != 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: design/sbbl_back.sv
// Back end: history rings, serial divider, level and attack per band.
`timescale 1ns / 1ps
module sbbl_back #(
	parameter int AVERAGE_DEPTH  = 16,
	parameter int MAGNITUDE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  logic [3:0][MAGNITUDE_BITS+8:0] q_head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [3:0][14:0]               levels,
	output logic [3:0][14:0]               attacks
);

	localparam int AW = MAGNITUDE_BITS + 9;
	localparam int DPW = $clog2(AVERAGE_DEPTH + 1);
	localparam int TW = AW + DPW;
	localparam int DW = AW + DPW + 8;
	localparam int SW = $clog2(AVERAGE_DEPTH);
	localparam int NW = $clog2(DW + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_TOTAL = 6'b000100,
		S_DIV   = 6'b001000,
		S_ATT   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t           st_q;
	logic [1:0]       band_q;
	logic [SW-1:0]    slot_q;
	logic             wrapped_q;
	logic [AW-1:0]    hist_mem [sbbl_pkg::NUM_BANDS][AVERAGE_DEPTH];
	logic [AW-1:0]    rd_q;
	logic [TW-1:0]    total_q [sbbl_pkg::NUM_BANDS];
	logic [14:0]      att_state_q [sbbl_pkg::NUM_BANDS];
	logic [3:0][14:0] level_w_q;
	logic [TW-1:0]    divisor_q;
	logic [TW-1:0]    rem_q;
	logic [DW-1:0]    dvd_q;
	logic [NW-1:0]    cnt_q;
	logic             out_valid_q;
	logic [3:0][14:0] out_level_q;
	logic [3:0][14:0] out_att_q;

	logic [AW-1:0]    intensity;
	logic [AW-1:0]    old_val;
	logic [TW-1:0]    tot_new;
	logic [TW:0]      trial;
	logic             ge;
	logic [16:0]      raw_c;
	logic [14:0]      level_c;
	logic [17:0]      att_sum;
	logic [33:0]      att_prod;
	logic [15:0]      att_div;
	logic [14:0]      att_c;
	logic             deliver;

	assign intensity = q_head[band_q];
	assign old_val   = wrapped_q ? rd_q : '0;
	assign tot_new   = total_q[band_q] - TW'(old_val) + TW'(intensity);
	assign trial     = {rem_q, dvd_q[DW-1]};
	assign ge        = (trial >= {1'b0, divisor_q});

	assign raw_c    = (dvd_q > DW'(sbbl_pkg::RAW_CLAMP)) ? sbbl_pkg::RAW_CLAMP : dvd_q[16:0];
	assign level_c  = (dvd_q > DW'(sbbl_pkg::LEVEL_MAX)) ? sbbl_pkg::LEVEL_MAX : dvd_q[14:0];
	assign att_sum  = 18'(3 * 18'(att_state_q[band_q])) + 18'({raw_c, 1'b0}) + 18'd2;
	assign att_prod = 34'(att_sum) * 34'(sbbl_pkg::RECIP5);
	assign att_div  = att_prod[33:18];
	assign att_c    = (att_div > 16'(sbbl_pkg::LEVEL_MAX)) ? sbbl_pkg::LEVEL_MAX : att_div[14:0];

	assign deliver   = (st_q == S_DONE) && (!out_valid_q || out_ready);
	assign pop       = deliver;
	assign out_valid = out_valid_q;
	assign levels    = out_level_q;
	assign attacks   = out_att_q;

	always_ff @(posedge clk) begin
		if (st_q == S_READ)
			rd_q <= hist_mem[band_q][slot_q];
		if (st_q == S_TOTAL)
			hist_mem[band_q][slot_q] <= intensity;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			band_q      <= '0;
			slot_q      <= '0;
			wrapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int b = 0; b < sbbl_pkg::NUM_BANDS; b++) begin
				total_q[b]     <= '0;
				att_state_q[b] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					band_q <= '0;
					if (q_valid)
						st_q <= S_READ;
				end
				S_READ: st_q <= S_TOTAL;
				S_TOTAL: begin
					total_q[band_q] <= tot_new;
					divisor_q       <= (tot_new == '0) ? TW'(1) : tot_new;
					dvd_q           <= (DW'(intensity) * DW'(AVERAGE_DEPTH)) << 8;
					rem_q           <= '0;
					cnt_q           <= NW'(DW);
					st_q            <= S_DIV;
				end
				S_DIV: begin
					rem_q <= ge ? TW'(trial - {1'b0, divisor_q}) : trial[TW-1:0];
					dvd_q <= {dvd_q[DW-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == NW'(1))
						st_q <= S_ATT;
				end
				S_ATT: begin
					level_w_q[band_q]   <= level_c;
					att_state_q[band_q] <= att_c;
					if (band_q == 2'd3) begin
						st_q <= S_DONE;
					end else begin
						band_q <= band_q + 1'b1;
						st_q   <= S_READ;
					end
				end
				S_DONE: begin
					if (deliver) begin
						out_valid_q <= 1'b1;
						if (slot_q == SW'(AVERAGE_DEPTH - 1)) begin
							slot_q    <= '0;
							wrapped_q <= 1'b1;
						end else begin
							slot_q <= slot_q + 1'b1;
						end
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			out_level_q <= level_w_q;
			for (int b = 0; b < sbbl_pkg::NUM_BANDS; b++)
				out_att_q[b] <= att_state_q[b];
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DIV) |-> (divisor_q != '0))
		else $error("divisor zero during division");

	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> q_valid)
		else $error("back end working without a queued frame");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_level_q[0] <= sbbl_pkg::LEVEL_MAX) &&
			(out_level_q[3] <= sbbl_pkg::LEVEL_MAX) && (out_att_q[3] <= sbbl_pkg::LEVEL_MAX))
		else $error("level out of range");

endmodule
